/* rtl/cle_pkg.sv */
// shared types and constants for the circular list engine
package cle_pkg;

    localparam int DEF_CAPACITY = 32;

    typedef enum logic [2:0] {
        REQ_APPEND     = 3'd0,
        REQ_INS_HEAD   = 3'd1,
        REQ_INS_AFTER  = 3'd2,
        REQ_DEL_HEAD   = 3'd3,
        REQ_DEL_TAIL   = 3'd4,
        REQ_DEL_MATCH  = 3'd5,
        REQ_SEARCH     = 3'd6,
        REQ_READ_ALL   = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

endpackage

/* rtl/cle_node_mem.sv */
// node store: value and link memories with one registered read port each
module cle_node_mem #(
    parameter int CAPACITY = cle_pkg::DEF_CAPACITY,
    parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          clk,
    input  logic [IW-1:0] rd_addr,
    output logic [31:0]   rd_value,
    output logic [IW-1:0] rd_link,
    input  logic          val_we,
    input  logic [IW-1:0] val_waddr,
    input  logic [31:0]   val_wdata,
    input  logic          lnk_we,
    input  logic [IW-1:0] lnk_waddr,
    input  logic [IW-1:0] lnk_wdata
);

    logic [31:0]   value_mem [CAPACITY];
    logic [IW-1:0] link_mem  [CAPACITY];

    // writes
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_waddr] <= val_wdata;
        end
        if (lnk_we)
        begin
            link_mem[lnk_waddr] <= lnk_wdata;
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        rd_value <= value_mem[rd_addr];
        rd_link  <= link_mem[rd_addr];
    end

endmodule

/* rtl/circular_list_engine.sv */
// top level of the circular list engine: sequencer around the node store
//
// A request takes one item and gives one result, or for read-all one
// result per entry. Status replies for an empty or full list go from the
// decide state straight to the output state; appends and inserts at the
// head pass through the link state, and delete-head reads the head node
// in the walk state first. Matching, delete-tail and read-all walk the
// link memory one node at a time, each address waiting for its registered
// read data. One request is in work at a time; a new item is taken only
// once the last result of the previous one has been taken.
module circular_list_engine #(
    parameter int CAPACITY = cle_pkg::DEF_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] new_value,
    input  logic signed [31:0] match_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic signed [31:0] data_value,
    output logic               last_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_WALK, S_LINK, S_OUT
    } state_t;

    state_t            state_reg;
    cle_pkg::req_t     req_reg;
    logic [31:0]       nv_reg, mv_reg;
    logic [CAPACITY-1:0] free_reg;
    logic [IW-1:0]     head_reg, tail_reg;
    logic [CW-1:0]     count_reg, step_reg;
    logic [IW-1:0]     cur_reg, prev_reg, at_reg;
    logic [IW-1:0]     slot_reg;

    logic [IW-1:0]     rd_addr;
    logic [31:0]       rd_value;
    logic [IW-1:0]     rd_link;
    logic              val_we, lnk_we;
    logic [IW-1:0]     val_waddr, lnk_waddr, lnk_wdata;

    logic              res_valid_reg;
    logic [1:0]        res_status_reg;
    logic              res_found_reg, res_last_reg;
    logic [31:0]       res_data_reg;

    logic [IW-1:0]     low_free;
    logic              empty_w, full_w;

    // lowest free slot
    always_comb
    begin
        low_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                low_free = IW'(i);
            end
        end
    end

    assign empty_w = (count_reg == '0);
    assign full_w  = (count_reg == CW'(CAPACITY));

    cle_node_mem #(.CAPACITY(CAPACITY), .IW(IW)) u_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_link  (rd_link),
        .val_we   (val_we),
        .val_waddr(val_waddr),
        .val_wdata(nv_reg),
        .lnk_we   (lnk_we),
        .lnk_waddr(lnk_waddr),
        .lnk_wdata(lnk_wdata)
    );

    // read address: the node being walked
    assign rd_addr = cur_reg;

    // value write port, used in the link stage only
    always_comb
    begin
        val_we    = 1'b0;
        val_waddr = slot_reg;
        if (state_reg == S_LINK)
        begin
            unique case (req_reg)
                cle_pkg::REQ_APPEND, cle_pkg::REQ_INS_HEAD:
                begin
                    val_we = 1'b1;
                end
                cle_pkg::REQ_INS_AFTER:
                begin
                    val_we = 1'b1;
                end
                default:
                begin
                    val_we = 1'b0;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign found       = res_found_reg;
    assign data_value  = res_data_reg;
    assign last_result = res_last_reg;

    // walk phase: address out, then registered read data back
    logic link_phase_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_reg       <= '1;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            link_phase_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg  <= cle_pkg::req_t'(req_type);
                        nv_reg   <= new_value;
                        mv_reg   <= match_value;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    res_found_reg <= 1'b0;
                    res_data_reg  <= '0;
                    res_last_reg  <= 1'b1;
                    res_status_reg <= cle_pkg::ST_OK;
                    cur_reg  <= head_reg;
                    prev_reg <= tail_reg;
                    step_reg <= '0;
                    slot_reg <= low_free;
                    link_phase_reg <= 1'b0;
                    if (req_reg == cle_pkg::REQ_INS_AFTER && empty_w)
                    begin
                        res_status_reg <= cle_pkg::ST_EMPTY;
                        state_reg <= S_OUT;
                    end
                    else if ((req_reg == cle_pkg::REQ_APPEND ||
                              req_reg == cle_pkg::REQ_INS_HEAD ||
                              req_reg == cle_pkg::REQ_INS_AFTER) && full_w)
                    begin
                        res_status_reg <= cle_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else if (req_reg != cle_pkg::REQ_APPEND &&
                             req_reg != cle_pkg::REQ_INS_HEAD && empty_w)
                    begin
                        res_status_reg <= cle_pkg::ST_EMPTY;
                        state_reg <= S_OUT;
                    end
                    else if (req_reg == cle_pkg::REQ_APPEND ||
                             req_reg == cle_pkg::REQ_INS_HEAD)
                    begin
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // wait for the registered read data at each node
                    if (!link_phase_reg)
                    begin
                        link_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        link_phase_reg <= 1'b0;
                        unique case (req_reg)
                            cle_pkg::REQ_READ_ALL:
                            begin
                                if (!res_valid_reg || out_ready)
                                begin
                                    res_valid_reg  <= 1'b1;
                                    res_status_reg <= cle_pkg::ST_OK;
                                    res_data_reg   <= rd_value;
                                    res_last_reg   <= (step_reg + 1'b1 == count_reg);
                                    step_reg <= step_reg + 1'b1;
                                    cur_reg  <= rd_link;
                                    if (step_reg + 1'b1 == count_reg)
                                    begin
                                        state_reg <= S_IDLE;
                                    end
                                end
                                else
                                begin
                                    link_phase_reg <= 1'b1;
                                end
                            end
                            cle_pkg::REQ_DEL_HEAD:
                            begin
                                at_reg       <= cur_reg;
                                res_data_reg <= rd_value;
                                slot_reg     <= rd_link;
                                state_reg    <= S_LINK;
                            end
                            cle_pkg::REQ_DEL_TAIL:
                            begin
                                if (cur_reg == tail_reg)
                                begin
                                    at_reg       <= cur_reg;
                                    res_data_reg <= rd_value;
                                    slot_reg     <= rd_link;
                                    state_reg    <= S_LINK;
                                end
                                else
                                begin
                                    prev_reg <= cur_reg;
                                    cur_reg  <= rd_link;
                                end
                            end
                            default:
                            begin
                                // match requests
                                if (rd_value == mv_reg)
                                begin
                                    at_reg <= cur_reg;
                                    if (req_reg == cle_pkg::REQ_SEARCH)
                                    begin
                                        res_found_reg <= 1'b1;
                                        state_reg <= S_OUT;
                                    end
                                    else
                                    begin
                                        if (req_reg == cle_pkg::REQ_DEL_MATCH)
                                        begin
                                            res_data_reg <= rd_value;
                                            slot_reg     <= rd_link;
                                        end
                                        else
                                        begin
                                            cur_reg <= rd_link;
                                        end
                                        state_reg <= S_LINK;
                                    end
                                end
                                else if (step_reg + 1'b1 == count_reg)
                                begin
                                    res_status_reg <= cle_pkg::ST_NOMATCH;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    step_reg <= step_reg + 1'b1;
                                    prev_reg <= cur_reg;
                                    cur_reg  <= rd_link;
                                end
                            end
                        endcase
                    end
                end
                S_LINK:
                begin
                    state_reg <= S_OUT;
                    unique case (req_reg)
                        cle_pkg::REQ_APPEND, cle_pkg::REQ_INS_HEAD:
                        begin
                            free_reg[slot_reg] <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                            if (empty_w)
                            begin
                                head_reg <= slot_reg;
                                tail_reg <= slot_reg;
                            end
                            else if (req_reg == cle_pkg::REQ_APPEND)
                            begin
                                tail_reg <= slot_reg;
                            end
                            else
                            begin
                                head_reg <= slot_reg;
                            end
                        end
                        cle_pkg::REQ_INS_AFTER:
                        begin
                            free_reg[slot_reg] <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                            if (at_reg == tail_reg)
                            begin
                                tail_reg <= slot_reg;
                            end
                        end
                        default:
                        begin
                            // deletes: slot_reg holds successor of at_reg
                            free_reg[at_reg] <= 1'b1;
                            if (count_reg == CW'(1))
                            begin
                                count_reg <= '0;
                                head_reg  <= '0;
                                tail_reg  <= '0;
                            end
                            else
                            begin
                                count_reg <= count_reg - 1'b1;
                                if (at_reg == head_reg)
                                begin
                                    head_reg <= slot_reg;
                                end
                                if (at_reg == tail_reg)
                                begin
                                    tail_reg <= prev_reg;
                                end
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!res_valid_reg || out_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // neighbour link writes driven in link stage, sharing the one link write port
    logic          l2_we;
    logic [IW-1:0] l2_addr, l2_data;

    always_comb
    begin
        l2_we   = 1'b0;
        l2_addr = prev_reg;
        l2_data = slot_reg;
        if (state_reg == S_LINK)
        begin
            unique case (req_reg)
                cle_pkg::REQ_APPEND, cle_pkg::REQ_INS_HEAD:
                begin
                    l2_we   = !empty_w;
                    l2_addr = tail_reg;
                    l2_data = slot_reg;
                end
                cle_pkg::REQ_INS_AFTER:
                begin
                    l2_we   = 1'b1;
                    l2_addr = at_reg;
                    l2_data = slot_reg;
                end
                default:
                begin
                    l2_we   = (count_reg != CW'(1));
                    l2_addr = prev_reg;
                    l2_data = slot_reg;
                end
            endcase
        end
    end

    // new node's own link goes through a registered, delayed write
    logic          nl_we_reg;
    logic [IW-1:0] nl_addr_reg, nl_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_we_reg <= 1'b0;
        end
        else
        begin
            nl_we_reg <= (state_reg == S_LINK) &&
                         (req_reg == cle_pkg::REQ_APPEND ||
                          req_reg == cle_pkg::REQ_INS_HEAD ||
                          req_reg == cle_pkg::REQ_INS_AFTER);
            nl_addr_reg <= slot_reg;
            if (req_reg == cle_pkg::REQ_INS_AFTER)
            begin
                nl_data_reg <= cur_reg;
            end
            else if (empty_w)
            begin
                nl_data_reg <= slot_reg;
            end
            else
            begin
                nl_data_reg <= head_reg;
            end
        end
    end

    // link port: new-node link (S_OUT) or neighbour link (S_LINK)
    assign lnk_we    = nl_we_reg || l2_we;
    assign lnk_waddr = nl_we_reg ? nl_addr_reg : l2_addr;
    assign lnk_wdata = nl_we_reg ? nl_data_reg : l2_data;

endmodule

/* tb/circular_list_engine_tb.sv */
// self-checking testbench for the circular list engine
`timescale 1ns / 100ps

module circular_list_engine_tb;

    localparam int CAP = 32;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] data_value;
        logic        last_result;
    } list_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic signed [31:0] new_value;
    logic signed [31:0] match_value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] data_value;
    logic               last_result;

    // shadow copy of the list
    logic [31:0] node_val [CAP];
    logic [4:0]  node_next [CAP];
    logic [CAP-1:0] free_map;
    logic [4:0]  head_q;
    logic [4:0]  tail_q;
    int          n_entries;

    list_result_t expected_q[$];
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  idle_cnt;
    bit  send_idle_en;
    bit  recv_idle_en;
    bit  hold_recv;
    bit  timed_out;

    circular_list_engine #(.CAPACITY(CAP)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .new_value(new_value), .match_value(match_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .data_value(data_value),
        .last_result(last_result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic list_result_t mk(logic [1:0] s, logic f, logic [31:0] d, logic l);
        list_result_t r;
        r.status = s;
        r.found = f;
        r.data_value = d;
        r.last_result = l;
        return r;
    endfunction

    // first slot from head holding v, with predecessor
    function automatic bit locate(logic [31:0] v, output logic [4:0] at, output logic [4:0] pv);
        logic [4:0] p;
        logic [4:0] c;
        p = tail_q;
        c = head_q;
        at = '0;
        pv = '0;
        for (int n = 0; n < n_entries; n++)
        begin
            if (node_val[c] == v)
            begin
                at = c;
                pv = p;
                return 1'b1;
            end
            p = c;
            c = node_next[c];
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] unlink(logic [4:0] c, logic [4:0] p);
        logic [31:0] v;
        v = node_val[c];
        if (n_entries <= 1)
        begin
            n_entries = 0;
            head_q = '0;
            tail_q = '0;
        end
        else
        begin
            node_next[p] = node_next[c];
            if (c == head_q)
                head_q = node_next[c];
            if (c == tail_q)
                tail_q = p;
            n_entries--;
        end
        free_map[c] = 1'b1;
        return v;
    endfunction

    // list behaviour: queues the results one request causes
    function automatic void predict_list(cle_pkg::req_t rq, logic [31:0] nv, logic [31:0] mv);
        bit empty;
        logic [4:0] at;
        logic [4:0] pv;
        logic [4:0] s;
        logic [4:0] c;
        empty = (n_entries == 0);
        if (rq == cle_pkg::REQ_APPEND || rq == cle_pkg::REQ_INS_HEAD ||
            rq == cle_pkg::REQ_INS_AFTER)
        begin
            if (rq == cle_pkg::REQ_INS_AFTER && empty)
                expected_q.push_back(mk(cle_pkg::ST_EMPTY, 1'b0, 32'h0, 1'b1));
            else if (n_entries >= CAP)
                expected_q.push_back(mk(cle_pkg::ST_FULL, 1'b0, 32'h0, 1'b1));
            else if (rq == cle_pkg::REQ_INS_AFTER && !locate(mv, at, pv))
                expected_q.push_back(mk(cle_pkg::ST_NOMATCH, 1'b0, 32'h0, 1'b1));
            else
            begin
                s = '0;
                for (int i = CAP - 1; i >= 0; i--)
                    if (free_map[i])
                        s = 5'(i);
                free_map[s] = 1'b0;
                node_val[s] = nv;
                if (empty)
                begin
                    node_next[s] = s;
                    head_q = s;
                    tail_q = s;
                end
                else if (rq == cle_pkg::REQ_INS_AFTER)
                begin
                    node_next[s] = node_next[at];
                    node_next[at] = s;
                    if (at == tail_q)
                        tail_q = s;
                end
                else
                begin
                    node_next[s] = head_q;
                    node_next[tail_q] = s;
                    if (rq == cle_pkg::REQ_APPEND)
                        tail_q = s;
                    else
                        head_q = s;
                end
                n_entries++;
                expected_q.push_back(mk(cle_pkg::ST_OK, 1'b0, 32'h0, 1'b1));
            end
            return;
        end
        if (empty)
        begin
            expected_q.push_back(mk(cle_pkg::ST_EMPTY, 1'b0, 32'h0, 1'b1));
            return;
        end
        case (rq)
            cle_pkg::REQ_DEL_HEAD:
                expected_q.push_back(mk(cle_pkg::ST_OK, 1'b0, unlink(head_q, tail_q), 1'b1));
            cle_pkg::REQ_DEL_TAIL:
            begin
                c = head_q;
                for (int n = 0; n + 1 < n_entries; n++)
                begin
                    if (node_next[c] == tail_q)
                        break;
                    c = node_next[c];
                end
                expected_q.push_back(mk(cle_pkg::ST_OK, 1'b0, unlink(tail_q, c), 1'b1));
            end
            cle_pkg::REQ_DEL_MATCH:
                if (!locate(mv, at, pv))
                    expected_q.push_back(mk(cle_pkg::ST_NOMATCH, 1'b0, 32'h0, 1'b1));
                else
                    expected_q.push_back(mk(cle_pkg::ST_OK, 1'b0, unlink(at, pv), 1'b1));
            cle_pkg::REQ_SEARCH:
                if (locate(mv, at, pv))
                    expected_q.push_back(mk(cle_pkg::ST_OK, 1'b1, 32'h0, 1'b1));
                else
                    expected_q.push_back(mk(cle_pkg::ST_NOMATCH, 1'b0, 32'h0, 1'b1));
            default:
            begin
                c = head_q;
                for (int n = 0; n < n_entries; n++)
                begin
                    expected_q.push_back(mk(cle_pkg::ST_OK, 1'b0, node_val[c],
                                            n + 1 == n_entries));
                    c = node_next[c];
                end
            end
        endcase
    endfunction

    // send one item, with a random gap in front when enabled
    task automatic send_req(cle_pkg::req_t rq, logic [31:0] nv, logic [31:0] mv);
        int gap;
        if (send_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        new_value <= nv;
        match_value <= mv;
        predict_list(rq, nv, mv);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // pick a value already in the list when there is one
    function automatic logic [31:0] some_member();
        logic [4:0] c;
        int k;
        if (n_entries == 0)
            return $urandom;
        c = head_q;
        k = $urandom_range(0, n_entries - 1);
        repeat (k) c = node_next[c];
        return node_val[c];
    endfunction

    task automatic test_empty_list();
        for (int r = cle_pkg::REQ_INS_AFTER; r <= cle_pkg::REQ_READ_ALL; r++)
            if (r != cle_pkg::REQ_INS_HEAD)
                send_req(cle_pkg::req_t'(3'(r)), 32'h1234_5678, 32'h0);
    endtask

    task automatic test_single_node();
        send_req(cle_pkg::REQ_INS_HEAD, 32'h8000_0000, 0);
        send_req(cle_pkg::REQ_SEARCH, 0, 32'h8000_0000);
        send_req(cle_pkg::REQ_READ_ALL, 0, 0);
        send_req(cle_pkg::REQ_DEL_TAIL, 0, 0);
        send_req(cle_pkg::REQ_APPEND, 32'h7FFF_FFFF, 0);
        send_req(cle_pkg::REQ_DEL_MATCH, 0, 32'h7FFF_FFFF);
    endtask

    task automatic test_matching();
        send_req(cle_pkg::REQ_APPEND, 32'hFFFF_FFFF, 0);
        send_req(cle_pkg::REQ_APPEND, 32'h0, 0);
        send_req(cle_pkg::REQ_APPEND, 32'hFFFF_FFFF, 0);
        send_req(cle_pkg::REQ_INS_AFTER, 32'h5555_AAAA, 32'h0);
        send_req(cle_pkg::REQ_INS_AFTER, 32'hAAAA_5555, 32'hFFFF_FFFF);
        send_req(cle_pkg::REQ_INS_AFTER, 32'h1, 32'h5555_AAAA);
        send_req(cle_pkg::REQ_INS_AFTER, 32'h2, 32'h3);
        send_req(cle_pkg::REQ_SEARCH, 0, 32'h1);
        send_req(cle_pkg::REQ_SEARCH, 0, 32'h3);
        send_req(cle_pkg::REQ_DEL_MATCH, 0, 32'hFFFF_FFFF);
        send_req(cle_pkg::REQ_DEL_MATCH, 0, 32'h3);
        send_req(cle_pkg::REQ_DEL_HEAD, 0, 0);
        send_req(cle_pkg::REQ_READ_ALL, 0, 0);
    endtask

    // fill past capacity, then drain with a read-out at the top
    task automatic test_full_store();
        while (n_entries < CAP)
            send_req($urandom_range(0, 1) ? cle_pkg::REQ_APPEND : cle_pkg::REQ_INS_HEAD,
                     $urandom, 0);
        send_req(cle_pkg::REQ_APPEND, 32'h1, 0);
        send_req(cle_pkg::REQ_INS_HEAD, 32'h2, 0);
        send_req(cle_pkg::REQ_INS_AFTER, 32'h3, some_member());
        send_req(cle_pkg::REQ_INS_AFTER, 32'h3, 32'hDEAD_BEEF);
        send_req(cle_pkg::REQ_READ_ALL, 0, 0);
        send_req(cle_pkg::REQ_DEL_MATCH, 0, some_member());
        send_req(cle_pkg::REQ_SEARCH, 0, some_member());
        while (n_entries > 0)
            send_req($urandom_range(0, 1) ? cle_pkg::REQ_DEL_TAIL : cle_pkg::REQ_DEL_HEAD,
                     0, 0);
    endtask

    // random requests biased to values present in the list
    task automatic test_random_traffic(int count);
        cle_pkg::req_t rq;
        logic [31:0] mv;
        for (int i = 0; i < count; i++)
        begin
            rq = cle_pkg::req_t'(3'($urandom_range(0, 7)));
            if (rq == cle_pkg::REQ_READ_ALL && $urandom_range(0, 2) != 0)
                rq = cle_pkg::REQ_SEARCH;
            if (n_entries < 4 && $urandom_range(0, 1))
                rq = cle_pkg::REQ_APPEND;
            mv = ($urandom_range(0, 3) != 0) ? some_member() : $urandom;
            send_req(rq, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom, mv);
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
            end
            test_random_traffic(10);
        join
    endtask

    // receiver ready, with idle bursts
    always @(posedge clk)
    begin
        if (!rst_n || hold_recv)
            out_ready <= 1'b0;
        else if (idle_cnt > 0)
        begin
            idle_cnt <= idle_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (recv_idle_en && $urandom_range(0, 5) == 0)
        begin
            idle_cnt <= $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // result checking
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got = mk(status, found, data_value, last_result);
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d found %0d/%0d data %h/%h last %0d/%0d",
                                 want.status, got.status, want.found, got.found,
                                 want.data_value, got.data_value,
                                 want.last_result, got.last_result);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("circular_list_engine_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        new_value = '0;
        match_value = '0;
        out_ready = 1'b0;
        free_map = '1;
        head_q = '0;
        tail_q = '0;
        n_entries = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cnt = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_recv = 1'b0;
        timed_out = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_single_node();
        test_matching();
        test_full_store();
        test_backpressure();
        test_random_traffic(125);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random_traffic(40);
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (CAP + 10) @(posedge clk);
        $display("covered %0d requests and %0d results, including empty, single-node,",
                 items_sent, results_seen);
        $display("full-store, match and back-pressure cases");
        if (mismatches == 0)
            $display("circular_list_engine_tb: PASS");
        else
            $display("circular_list_engine_tb: FAIL");
        $finish;
    end

endmodule
